@@ sv/packed_sample_unpacker_core_assert.svh @@
// Assertion macros for the packed sample unpacker checker.
// Depends on nothing; included by the checker file.
`ifndef PACKED_SAMPLE_UNPACKER_CORE_ASSERT_SVH
`define PACKED_SAMPLE_UNPACKER_CORE_ASSERT_SVH

// Implication in the same cycle, off during reset
`define SPU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spu check failed");

// Implication into the next cycle, off during reset
`define SPU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spu check failed");

// Implication into the next cycle, also checked in reset
`define SPU_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spu check failed");

`endif

@@ sv/spu_pkg.sv @@
// Shared types and constants of the packed sample unpacker.
// Depends on nothing; used by every RTL module.
package spu_pkg;

    localparam int MAX_COLUMNS = 8192;
    localparam int COLS_W      = 14;
    localparam int LEFT_W      = 17;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAX        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd4;

    // Width codes
    localparam logic [2:0] WCODE_1  = 3'd0;
    localparam logic [2:0] WCODE_2  = 3'd1;
    localparam logic [2:0] WCODE_4  = 3'd2;
    localparam logic [2:0] WCODE_8  = 3'd3;
    localparam logic [2:0] WCODE_16 = 3'd4;

    // Color modes
    localparam logic [1:0] MODE_GREY    = 2'd0;
    localparam logic [1:0] MODE_GREY_A  = 2'd1;
    localparam logic [1:0] MODE_RGB     = 2'd2;
    localparam logic [1:0] MODE_PALETTE = 2'd3;

    // log2 of sample width within one byte
    localparam logic [1:0] WLOG_1 = 2'd0;
    localparam logic [1:0] WLOG_2 = 2'd1;
    localparam logic [1:0] WLOG_4 = 2'd2;
    localparam logic [1:0] WLOG_8 = 2'd3;

    // One classified byte, queued between front and back
    typedef struct packed {
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
        logic               row_end;
        logic [1:0]         wlog;
        logic               scale;
        logic               fax;
    } entry_t;

endpackage

@@ sv/spu_front.sv @@
// Front end: configuration registers, row counter and byte classification.
// Depends on spu_pkg.
module spu_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [spu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          push_valid,
    input  logic                          push_ready,
    output spu_pkg::entry_t               push_entry
);

    logic [2:0]                   wcode_reg;
    logic [2:0]                   spp_reg;
    logic [1:0]                   mode_reg;
    logic                         fax_reg;
    logic [spu_pkg::COLS_W-1:0]   cols_reg;
    logic [spu_pkg::LEFT_W-1:0]   left_reg;
    logic [spu_pkg::LEFT_W-1:0]   left_next;

    logic [2:0]                   code;
    logic [1:0]                   wlog;
    logic                         is16;
    logic [2:0]                   ch;
    logic [spu_pkg::COLS_W-1:0]   cols;
    logic [15:0]                  chcols;
    logic [spu_pkg::LEFT_W-1:0]   load;
    logic [spu_pkg::LEFT_W-1:0]   left_eff;
    logic                         fax;
    logic                         scale;
    logic [spu_pkg::COUNT_W-1:0]  units;
    logic [spu_pkg::COUNT_W-1:0]  consumed;
    logic [spu_pkg::COUNT_W-1:0]  count;
    logic                         accept;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcode_reg <= spu_pkg::WCODE_8;
            spp_reg   <= 3'd1;
            mode_reg  <= spu_pkg::MODE_GREY;
            fax_reg   <= 1'b0;
            cols_reg  <= spu_pkg::COLS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                spu_pkg::REG_WIDTH_CODE: wcode_reg <= cfg_data[2:0];
                spu_pkg::REG_SPP:        spp_reg   <= cfg_data[2:0];
                spu_pkg::REG_COLOR_MODE: mode_reg  <= cfg_data[1:0];
                spu_pkg::REG_FAX:        fax_reg   <= cfg_data[0];
                spu_pkg::REG_COLUMNS:    cols_reg  <= cfg_data[spu_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the sample layout
    always_comb begin
        code = (wcode_reg > spu_pkg::WCODE_16) ? spu_pkg::WCODE_16 : wcode_reg;
        is16 = (code == spu_pkg::WCODE_16);
        wlog = (code >= spu_pkg::WCODE_8) ? spu_pkg::WLOG_8 : code[1:0];

        if (spp_reg == 3'd0)      ch = 3'd1;
        else if (spp_reg > 3'd4)  ch = 3'd4;
        else                      ch = spp_reg;
        if (mode_reg == spu_pkg::MODE_GREY || mode_reg == spu_pkg::MODE_PALETTE) ch = 3'd1;

        if (cols_reg == '0)                                  cols = spu_pkg::COLS_W'(1);
        else if (cols_reg > spu_pkg::COLS_W'(spu_pkg::MAX_COLUMNS))
            cols = spu_pkg::COLS_W'(spu_pkg::MAX_COLUMNS);
        else                                                 cols = cols_reg;

        scale = (mode_reg == spu_pkg::MODE_GREY_A || mode_reg == spu_pkg::MODE_RGB)
                && (wlog != spu_pkg::WLOG_8);
        fax   = fax_reg && (mode_reg == spu_pkg::MODE_GREY) && (code == spu_pkg::WCODE_1);
    end

    // Row length in reads: columns times channels, doubled at 16 bits
    always_comb begin
        case (ch)
            3'd2:    chcols = {1'b0, cols, 1'b0};
            3'd3:    chcols = 16'(cols) + {1'b0, cols, 1'b0};
            3'd4:    chcols = {cols, 2'b00};
            default: chcols = 16'(cols);
        endcase
        load     = is16 ? {chcols, 1'b0} : {1'b0, chcols};
        left_eff = (left_reg == '0) ? load : left_reg;
    end

    // Reads taken from this byte and the results they make
    always_comb begin
        units = fax ? 4'd8 : (4'd8 >> wlog);
        if (left_eff >= spu_pkg::LEFT_W'(units)) begin
            consumed  = units;
            left_next = left_eff - spu_pkg::LEFT_W'(units);
        end else begin
            consumed  = left_eff[spu_pkg::COUNT_W-1:0];
            left_next = '0;
        end
        count = fax ? (consumed >> 1) : consumed;
    end

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Advance the row counter once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (accept) begin
            left_reg <= left_next;
        end
    end

    // Queue only bytes that give results
    assign push_valid         = accept && (count != '0);
    assign push_entry.data    = s_data_byte;
    assign push_entry.count   = count;
    assign push_entry.row_end = fax ? (left_next <= spu_pkg::LEFT_W'(1)) : (left_next == '0);
    assign push_entry.wlog    = wlog;
    assign push_entry.scale   = scale;
    assign push_entry.fax     = fax;

endmodule

@@ sv/spu_queue.sv @@
// Short register queue between the front and back ends.
// Depends on spu_pkg.
module spu_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  spu_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output spu_pkg::entry_t pop_entry
);

    spu_pkg::entry_t                  mem_reg [spu_pkg::QUEUE_DEPTH];
    logic [spu_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [spu_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [spu_pkg::QUEUE_CW-1:0]     count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != spu_pkg::QUEUE_CW'(spu_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ sv/spu_back.sv @@
// Back end: walks one queued byte, one result per cycle unless the
// output stalls, into the output register. Depends on spu_pkg.
module spu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  spu_pkg::entry_t pop_entry,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_sample_byte,
    output logic            m_last_of_byte,
    output logic            m_row_end
);

    spu_pkg::entry_t                 cur_reg;
    logic                            cur_valid_reg;
    logic [7:0]                      sh_reg;
    logic [spu_pkg::COUNT_W-1:0]     idx_reg;
    logic                            m_valid_reg;
    logic [7:0]                      sample_reg;
    logic                            last_reg;
    logic                            rend_reg;

    logic                            out_free;
    logic                            emit;
    logic                            is_last;
    logic                            load;
    logic [7:0]                      sample_next;
    logic [7:0]                      sh_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign is_last   = (idx_reg == cur_reg.count - 1'b1);
    assign load      = !cur_valid_reg || (emit && is_last);
    assign pop_ready = load;

    // Pick the sample at the top of the shift register
    always_comb begin
        if (cur_reg.fax) begin
            sample_next = {6'd0, 2'({1'b0, sh_reg[7]} + {1'b0, sh_reg[6]})};
            sh_next     = {sh_reg[5:0], 2'b00};
        end else begin
            case (cur_reg.wlog)
                spu_pkg::WLOG_1: begin
                    sample_next = cur_reg.scale ? (sh_reg & 8'h80) : (sh_reg >> 7);
                    sh_next     = {sh_reg[6:0], 1'b0};
                end
                spu_pkg::WLOG_2: begin
                    sample_next = cur_reg.scale ? (sh_reg & 8'hC0) : (sh_reg >> 6);
                    sh_next     = {sh_reg[5:0], 2'b00};
                end
                spu_pkg::WLOG_4: begin
                    sample_next = cur_reg.scale ? (sh_reg & 8'hF0) : (sh_reg >> 4);
                    sh_next     = {sh_reg[3:0], 4'b0000};
                end
                default: begin
                    sample_next = sh_reg;
                    sh_next     = '0;
                end
            endcase
        end
    end

    // Hold the current byte, advance through its samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
        end else if (load) begin
            cur_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= pop_entry;
            sh_reg  <= pop_entry.data;
            idx_reg <= '0;
        end else if (emit) begin
            sh_reg  <= sh_next;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            sample_reg <= sample_next;
            last_reg   <= is_last;
            rend_reg   <= is_last && cur_reg.row_end;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_byte  = sample_reg;
    assign m_last_of_byte = last_reg;
    assign m_row_end      = rend_reg;

endmodule

@@ sv/packed_sample_unpacker_core.sv @@
// Packed sample unpacker, top level: front end, queue, back end.
// Depends on spu_pkg, spu_front, spu_queue, spu_back.
//
// Use: packed scanline bytes enter on s_valid/s_ready/s_data_byte, most
// significant sample first. Each sample leaves as one byte on m_valid/m_ready
// with m_last_of_byte on the final result of a byte and m_row_end on the
// final result of an image row. A 16-bit sample leaves as two bytes.
// Registers are written over cfg_valid/cfg_ready (always ready) by index
// cfg_index with cfg_data; the user must do so only while no beat is in
// flight, which the block does not enforce. The first result of a byte goes
// from the queue through the back end's current-byte register to the output
// register. The back end emits one result per cycle while the output is not
// stalled, so a full byte gives 8 results at 1 bit, 4 at 2 bits or in fax
// halving, 2 at 4 bits and 1 at 8 or 16 bits. A four-entry queue lets the
// front take beats as the back end works; pad and no-result bytes skip it.
// Reset: registers return to 8-bit grey, one column; row counter and queue
// clear. When the receiver stalls, the output register holds its result, the
// back end waits, the queue fills and then s_ready drops.
module packed_sample_unpacker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_sample_byte,
    output logic                           m_last_of_byte,
    output logic                           m_row_end
);

    logic            push_valid;
    logic            push_ready;
    spu_pkg::entry_t push_entry;
    logic            pop_valid;
    logic            pop_ready;
    spu_pkg::entry_t pop_entry;

    assign cfg_ready = 1'b1;

    spu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    spu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    spu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_byte  (m_sample_byte),
        .m_last_of_byte (m_last_of_byte),
        .m_row_end      (m_row_end)
    );

endmodule

@@ sv/spu_checker.sv @@
// Port-level checks on the packed sample unpacker, bound to the top level.
// Depends on packed_sample_unpacker_core_assert.svh.
`include "packed_sample_unpacker_core_assert.svh"

module spu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_sample_byte,
    input logic       m_last_of_byte,
    input logic       m_row_end
);

    // A stalled result stays put
    `SPU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_byte) && $stable(m_row_end))

    // A row always ends on the last result of a byte
    `SPU_ASSERT_IMPL(a_row_end_last, aclk, aresetn, m_valid && m_row_end, m_last_of_byte)

    // Reset empties the output
    `SPU_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind packed_sample_unpacker_core spu_checker u_spu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sample_byte  (m_sample_byte),
    .m_last_of_byte (m_last_of_byte),
    .m_row_end      (m_row_end)
);
